[src/expadb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, widths and types of the exp approximation pipeline.
package expadb_pkg;

    localparam int X_W     = 32;
    localparam int Z_W     = 32;
    localparam int D_W     = 43;
    localparam int Q_W     = 40;
    localparam int EXP_W   = 11;
    localparam int RES_W   = 63;
    localparam int PROD_W  = 65;

    localparam int INPUT_FRAC_BITS_DEF = 21;

    localparam logic [32:0]       LOG2E_Q32   = 33'd6196328019;
    localparam logic [PROD_W-1:0] CLAMP_Q32   = 65'd4389456576512;
    localparam logic [32:0]       Q_INT_SAT   = 33'd2046;
    localparam logic [D_W-1:0]    C3_Q40      = 43'd5324470648832;
    localparam logic [44:0]       A_Q40       = 45'd30487625334784;
    localparam logic [42:0]       C2_Q40      = 43'd6295739826176;
    localparam logic [38:0]       B_Q40       = 39'd538906134528;
    localparam logic [RES_W-1:0]  POS_INF_BITS = 63'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic             sat;
        logic [EXP_W-1:0] expo;
        logic [Z_W-1:0]   frac;
    } side_t;

    typedef struct packed {
        logic             sat;
        logic [RES_W-1:0] bits;
    } res_t;

endpackage

[src/expadb_front.sv]
`timescale 1ns / 1ps
// Front stages: take magnitude, scale by log2(e), round, clamp, split into exponent and fraction, form divisor.
module expadb_front #(
    parameter int INPUT_FRAC_BITS = expadb_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [expadb_pkg::X_W-1:0]  in_x,
    output logic                               out_valid,
    output logic [expadb_pkg::D_W-1:0]         out_d,
    output expadb_pkg::side_t                  out_side
);
    import expadb_pkg::*;

    localparam logic [PROD_W-1:0] RND = (PROD_W'(1) << INPUT_FRAC_BITS) - PROD_W'(1);

    logic [4:0]        valid_reg;
    logic [X_W-1:0]    x_bits;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [X_W-1:0]    mag_reg, mag_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] sh_reg, sh_next;
    logic [PROD_W-1:0] q_reg, q_next;
    logic [D_W-1:0]    d_reg, d_next;
    side_t             side_reg, side_next;

    assign x_bits = in_x;

    always_comb begin
        mag_next  = x_bits[X_W-1] ? X_W'(~x_bits + X_W'(1)) : x_bits;
        prod_next = PROD_W'(mag_reg) * PROD_W'(LOG2E_Q32);
        sh_next   = neg2_reg ? ((prod_reg + RND) >> INPUT_FRAC_BITS)
                             : (prod_reg >> INPUT_FRAC_BITS);
        if (neg3_reg) begin
            q_next = CLAMP_Q32 - ((sh_reg > CLAMP_Q32) ? CLAMP_Q32 : sh_reg);
        end else begin
            q_next = CLAMP_Q32 + sh_reg;
        end
        side_next.sat  = (q_reg[PROD_W-1:32] >= Q_INT_SAT);
        side_next.expo = q_reg[32+EXP_W-1:32] + EXP_W'(1);
        side_next.frac = q_reg[Z_W-1:0];
        d_next         = C3_Q40 - {3'b000, q_reg[Z_W-1:0], 8'h00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= x_bits[X_W-1];
            mag_reg  <= mag_next;
            neg2_reg <= neg1_reg;
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
            sh_reg   <= sh_next;
            q_reg    <= q_next;
            d_reg    <= d_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_d     = d_reg;
    assign out_side  = side_reg;

endmodule

[src/expadb_recip.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit of 2^80 / d per stage.
module expadb_recip (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [expadb_pkg::D_W-1:0]  in_d,
    input  expadb_pkg::side_t           in_side,
    output logic                        out_valid,
    output logic [expadb_pkg::Q_W-1:0]  out_recip,
    output expadb_pkg::side_t           out_side
);
    import expadb_pkg::*;

    localparam logic [D_W-1:0] REM_INIT = D_W'(1) << Q_W;

    logic [Q_W-1:0] valid_reg;
    logic [Q_W-1:0] valid_src;
    logic [D_W-1:0] rem_reg  [Q_W];
    logic [D_W-1:0] rem_src  [Q_W];
    logic [D_W-1:0] rem_next [Q_W];
    logic [D_W-1:0] d_reg    [Q_W];
    logic [D_W-1:0] d_src    [Q_W];
    logic [Q_W-1:0] quo_reg  [Q_W];
    logic [Q_W-1:0] quo_src  [Q_W];
    logic [Q_W-1:0] quo_next [Q_W];
    side_t          side_reg [Q_W];
    side_t          side_src [Q_W];
    logic [D_W:0]   shifted  [Q_W];
    logic [Q_W-1:0] fits;

    always_comb begin
        valid_src[0] = in_valid;
        rem_src[0]   = REM_INIT;
        d_src[0]     = in_d;
        quo_src[0]   = '0;
        side_src[0]  = in_side;
        for (int k = 1; k < Q_W; k++) begin
            valid_src[k] = valid_reg[k-1];
            rem_src[k]   = rem_reg[k-1];
            d_src[k]     = d_reg[k-1];
            quo_src[k]   = quo_reg[k-1];
            side_src[k]  = side_reg[k-1];
        end
        for (int k = 0; k < Q_W; k++) begin
            shifted[k]  = {rem_src[k], 1'b0};
            fits[k]     = (shifted[k] >= {1'b0, d_src[k]});
            rem_next[k] = fits[k] ? D_W'(shifted[k] - {1'b0, d_src[k]}) : D_W'(shifted[k]);
            quo_next[k] = quo_src[k];
            quo_next[k][Q_W-1-k] = fits[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < Q_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                d_reg[k]    <= d_src[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_recip = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

[src/expadb_corr.sv]
`timescale 1ns / 1ps
// Correction stages: split products, rational correction, exponent merge and saturation.
module expadb_corr (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [expadb_pkg::Q_W-1:0]  in_recip,
    input  expadb_pkg::side_t           in_side,
    output logic                        out_valid,
    output expadb_pkg::res_t            out_res
);
    import expadb_pkg::*;

    localparam int C_W   = 46;
    localparam int TOT_W = 66;

    localparam logic [31:0] A_LO = A_Q40[31:0];
    localparam logic [12:0] A_HI = A_Q40[44:32];
    localparam logic [31:0] B_LO = B_Q40[31:0];
    localparam logic [6:0]  B_HI = B_Q40[38:32];

    logic [3:0]       valid_reg;
    logic [63:0]      pll_reg, pll_next;
    logic [39:0]      plh_reg, plh_next;
    logic [44:0]      phl_reg, phl_next;
    logic [20:0]      phh_reg, phh_next;
    logic [63:0]      bl_reg, bl_next;
    logic [38:0]      bh_reg, bh_next;
    side_t            side1_reg, side2_reg, side3_reg;
    logic [84:0]      full_sum;
    logic [70:0]      bz_sum;
    logic [44:0]      t_reg, t_next;
    logic [38:0]      bz_reg, bz_next;
    logic [C_W-1:0]   c_reg, c_next;
    logic [TOT_W-1:0] total;
    logic             over;
    res_t             res_reg, res_next;

    always_comb begin
        pll_next = 64'(A_LO) * 64'(in_recip[31:0]);
        plh_next = 40'(A_LO) * 40'(in_recip[39:32]);
        phl_next = 45'(A_HI) * 45'(in_recip[31:0]);
        phh_next = 21'(A_HI) * 21'(in_recip[39:32]);
        bl_next  = 64'(B_LO) * 64'(in_side.frac);
        bh_next  = 39'(B_HI) * 39'(in_side.frac);

        full_sum = 85'(pll_reg) + (85'(plh_reg) << 32) + (85'(phl_reg) << 32)
                 + (85'(phh_reg) << 64);
        t_next   = full_sum[84:40];
        bz_sum   = 71'(bl_reg) + (71'(bh_reg) << 32);
        bz_next  = bz_sum[70:32];

        c_next   = C_W'(t_reg) - C_W'(C2_Q40) - C_W'(bz_reg);

        total    = {3'b000, side3_reg.expo, 52'h0}
                 + ({{(TOT_W-C_W){c_reg[C_W-1]}}, c_reg} << 12);
        over     = (total >= TOT_W'(POS_INF_BITS));
        res_next.sat  = side3_reg.sat | over;
        res_next.bits = res_next.sat ? POS_INF_BITS : total[RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pll_reg   <= pll_next;
            plh_reg   <= plh_next;
            phl_reg   <= phl_next;
            phh_reg   <= phh_next;
            bl_reg    <= bl_next;
            bh_reg    <= bh_next;
            side1_reg <= in_side;
            t_reg     <= t_next;
            bz_reg    <= bz_next;
            side2_reg <= side1_reg;
            c_reg     <= c_next;
            side3_reg <= side2_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_res   = res_reg;

endmodule

[src/expadb_outbuf.sv]
`timescale 1ns / 1ps
// Output register with skid stage; freezes the pipeline only while the skid word is held.
module expadb_outbuf (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          en,
    input  logic                          fin_valid,
    input  expadb_pkg::res_t              fin_res,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [expadb_pkg::RES_W-1:0]  m_result_bits,
    output logic                          m_saturated
);
    import expadb_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, skid_reg;
    logic take, from_skid, from_fin, load_skid;

    assign en   = !skid_valid_reg;
    assign take = en && fin_valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        from_skid       = 1'b0;
        from_fin        = 1'b0;
        load_skid       = 1'b0;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                from_skid       = 1'b1;
            end else begin
                out_valid_next = take;
                from_fin       = take;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (from_skid) begin
            out_reg <= skid_reg;
        end else if (from_fin) begin
            out_reg <= fin_res;
        end
        if (load_skid) begin
            skid_reg <= fin_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_bits = out_reg.bits;
    assign m_saturated   = out_reg.sat;

endmodule

[src/exp_approx_double_bits_unit.sv]
`timescale 1ns / 1ps
// Top level of the e^x approximation unit producing IEEE-754 double bit patterns.
// Takes one word per cycle while s_ready is high and returns one word per input, in order.
// The path runs through the 5 front stages (magnitude, scale, round, clamp, split), the
// 40-stage restoring divider that forms 2^80/d one quotient bit per stage, 4 correction
// stages and the output register. A skid stage lets one more word enter while a result
// waits; s_ready drops only while that skid word is held.
// Results at or beyond the top exponent come out as +infinity with m_saturated set.
module exp_approx_double_bits_unit #(
    parameter int INPUT_FRAC_BITS = expadb_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [expadb_pkg::X_W-1:0]  s_x_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [expadb_pkg::RES_W-1:0]       m_result_bits,
    output logic                               m_saturated
);
    import expadb_pkg::*;

    logic           en;
    logic           front_valid, recip_valid, fin_valid;
    logic [D_W-1:0] front_d;
    side_t          front_side, recip_side;
    logic [Q_W-1:0] recip_q;
    res_t           fin_res;

    assign s_ready = en;

    expadb_front #(
        .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && en),
        .in_x      (s_x_value),
        .out_valid (front_valid),
        .out_d     (front_d),
        .out_side  (front_side)
    );

    expadb_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_d      (front_d),
        .in_side   (front_side),
        .out_valid (recip_valid),
        .out_recip (recip_q),
        .out_side  (recip_side)
    );

    expadb_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (recip_valid),
        .in_recip  (recip_q),
        .in_side   (recip_side),
        .out_valid (fin_valid),
        .out_res   (fin_res)
    );

    expadb_outbuf u_outbuf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .fin_valid     (fin_valid),
        .fin_res       (fin_res),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_bits (m_result_bits),
        .m_saturated   (m_saturated)
    );

endmodule
